>>> hw/rtl/irdf_pkg.sv
package irdf_pkg;
    localparam int WINDOW_SIZE_DEF = 7;
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 24;
    localparam int NUM_BITS        = 24;
    localparam int OFS_BITS        = 13;
    localparam int DIST_BITS       = 16;
    localparam int ALPHA_BITS      = 17;
    localparam int LIMIT_BITS      = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_RIGHT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFS_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_FRONT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFS_FRONT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIST    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIST    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA       = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVALID_LIM = 3'd7;

    typedef struct packed {
        logic [NUM_BITS-1:0]   numerator_right;
        logic [OFS_BITS-1:0]   offset_right;
        logic [NUM_BITS-1:0]   numerator_front;
        logic [OFS_BITS-1:0]   offset_front;
        logic [DIST_BITS-1:0]  min_distance;
        logic [DIST_BITS-1:0]  max_distance;
        logic [ALPHA_BITS-1:0] alpha_q16;
        logic [LIMIT_BITS-1:0] invalid_limit;
    } cfg_t;
endpackage

>>> hw/rtl/irdf_if.sv
interface irdf_in_if #(parameter int SAMPLE_BITS = 12) ();
    logic                   valid;
    logic                   ready;
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample;
    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface irdf_out_if ();
    logic        valid;
    logic        ready;
    logic        out_channel;
    logic [15:0] calibrated_distance;
    logic [15:0] filtered_distance;
    modport source (output valid, output out_channel, output calibrated_distance,
                    output filtered_distance, input ready);
    modport sink (input valid, input out_channel, input calibrated_distance,
                  input filtered_distance, output ready);
endinterface

interface irdf_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/irdf_front.sv
// Collects windows and finds the median by an odd-even transposition sort,
// one pass per cycle, then hands channel and median to the queue.
module irdf_front
    import irdf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_channel,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   med_valid,
    input  logic                   med_ready,
    output logic                   med_channel,
    output logic [SAMPLE_BITS-1:0] med_value
);
    localparam int FB = $clog2(WINDOW_SIZE + 1);
    localparam int IB = $clog2(WINDOW_SIZE);
    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_SORT    = 2'd1;
    localparam logic [1:0] ST_SEND    = 2'd2;

    logic [SAMPLE_BITS-1:0] win_reg [2][WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] srt_reg [WINDOW_SIZE];
    logic [FB-1:0]          fill_reg [2];
    logic [FB-1:0]          pass_reg;
    logic [1:0]             state_reg;
    logic                   ch_reg;
    logic                   acc;

    assign in_ready    = (state_reg == ST_COLLECT);
    assign acc         = in_valid && in_ready;
    assign med_valid   = (state_reg == ST_SEND);
    assign med_channel = ch_reg;
    assign med_value   = srt_reg[WINDOW_SIZE/2];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            win_reg[in_channel][fill_reg[in_channel][IB-1:0]] <= in_sample;
            if (fill_reg[in_channel] == FB'(WINDOW_SIZE - 1))
            begin
                for (int i = 0; i < WINDOW_SIZE - 1; i++)
                begin
                    srt_reg[i] <= win_reg[in_channel][i];
                end
                srt_reg[WINDOW_SIZE-1] <= in_sample;
            end
        end
        else if (state_reg == ST_SORT)
        begin
            for (int i = 0; i + 1 < WINDOW_SIZE; i++)
            begin
                if ((i % 2) == int'(pass_reg[0]))
                begin
                    if (srt_reg[i] > srt_reg[i+1])
                    begin
                        srt_reg[i]   <= srt_reg[i+1];
                        srt_reg[i+1] <= srt_reg[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            pass_reg    <= '0;
            ch_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_COLLECT:
                begin
                    if (acc)
                    begin
                        if (fill_reg[in_channel] == FB'(WINDOW_SIZE - 1))
                        begin
                            fill_reg[in_channel] <= '0;
                            ch_reg    <= in_channel;
                            pass_reg  <= '0;
                            state_reg <= ST_SORT;
                        end
                        else
                        begin
                            fill_reg[in_channel] <= fill_reg[in_channel] + FB'(1);
                        end
                    end
                end
                ST_SORT:
                begin
                    pass_reg <= pass_reg + FB'(1);
                    if (pass_reg == FB'(WINDOW_SIZE - 1))
                    begin
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    if (med_ready)
                    begin
                        state_reg <= ST_COLLECT;
                    end
                end
                default: state_reg <= ST_COLLECT;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] < FB'(WINDOW_SIZE) && fill_reg[1] < FB'(WINDOW_SIZE))
        else $error("window fill out of range");
    a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT && pass_reg == FB'(WINDOW_SIZE - 1)) |=> med_valid)
        else $error("sort did not finish");
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        med_valid |-> !in_ready)
        else $error("input accepted while median pending");
endmodule

>>> hw/rtl/irdf_queue.sv
// Two-entry queue between the median stage and the arithmetic stage.
module irdf_queue
    import irdf_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("queue pointers inconsistent");
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid && !rd_ready) |=> rd_valid)
        else $error("queue lost an entry");
endmodule

>>> hw/rtl/irdf_back.sv
// Serial restoring divide and offset (max distance for an invalid median), clamp, then the exponential moving average.
module irdf_back
    import irdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   med_valid,
    output logic                   med_ready,
    input  logic                   med_channel,
    input  logic [SAMPLE_BITS-1:0] med_value,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic                   res_channel,
    output logic [DIST_BITS-1:0]   res_cal,
    output logic [DIST_BITS-1:0]   res_filt
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CLAMP = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg;
    logic                   ch_reg;
    logic                   inv_reg;
    logic [SAMPLE_BITS-1:0] div_reg;
    logic [NUM_BITS-1:0]    quo_reg;
    logic [SAMPLE_BITS:0]   rem_reg;
    logic [4:0]             bit_reg;
    logic [DIST_BITS-1:0]   cal_reg, filt_reg;
    logic [DIST_BITS-1:0]   ema_reg [2];
    logic [1:0]             seed_reg;
    logic [33:0]            p1_reg, p2_reg;
    logic [SAMPLE_BITS:0]   rem_sh, rem_sub;
    logic [OFS_BITS-1:0]    ofs;
    logic signed [NUM_BITS+1:0] raw_dist;
    logic [NUM_BITS-1:0]    num;
    logic [ALPHA_BITS-1:0]  alpha;
    logic [DIST_BITS-1:0]   prev;
    logic [34:0]            sum;

    assign num   = ch_reg ? cfg.numerator_front : cfg.numerator_right;
    assign ofs   = ch_reg ? cfg.offset_front : cfg.offset_right;
    assign rem_sh  = {rem_reg[SAMPLE_BITS-1:0], num[bit_reg]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign raw_dist = inv_reg ? $signed({{(NUM_BITS-DIST_BITS+2){1'b0}}, cfg.max_distance})
                              : $signed({2'b00, quo_reg})
                                + {{(NUM_BITS+2-OFS_BITS){ofs[OFS_BITS-1]}}, ofs};
    assign alpha = cfg.alpha_q16[16] ? 17'h10000 : cfg.alpha_q16;
    assign prev  = seed_reg[ch_reg] ? ema_reg[ch_reg] : cal_reg;
    assign sum   = {1'b0, p1_reg} + {1'b0, p2_reg} + 35'd32768;

    assign med_ready   = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_OUT);
    assign res_channel = ch_reg;
    assign res_cal     = cal_reg;
    assign res_filt    = filt_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ch_reg  <= med_channel;
                div_reg <= med_value;
                inv_reg <= ({{(16-SAMPLE_BITS){1'b0}}, med_value} <=
                            {4'd0, cfg.invalid_limit});
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, div_reg})
                begin
                    rem_reg <= rem_sub;
                    quo_reg[bit_reg] <= 1'b1;
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg[bit_reg] <= 1'b0;
                end
            end
            ST_CLAMP:
            begin
                if (raw_dist < $signed({10'd0, cfg.min_distance}))
                begin
                    cal_reg <= cfg.min_distance;
                end
                else if (raw_dist > $signed({10'd0, cfg.max_distance}))
                begin
                    cal_reg <= cfg.max_distance;
                end
                else
                begin
                    cal_reg <= raw_dist[DIST_BITS-1:0];
                end
            end
            ST_MUL:
            begin
                p1_reg <= 34'(alpha * cal_reg);
                p2_reg <= 34'((18'h10000 - {1'b0, alpha}) * prev);
            end
            ST_SUM:
            begin
                filt_reg <= sum[31:16];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bit_reg    <= '0;
            seed_reg   <= '0;
            ema_reg[0] <= '0;
            ema_reg[1] <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    bit_reg <= 5'(NUM_BITS - 1);
                    if (med_valid)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                    begin
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_SUM;
                ST_SUM:
                begin
                    ema_reg[ch_reg]  <= sum[31:16];
                    seed_reg[ch_reg] <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> seed_reg[ch_reg])
        else $error("result without seeded average");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && bit_reg == 5'd0) |=> state_reg == ST_CLAMP)
        else $error("divider did not finish");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !med_ready)
        else $error("median taken while result pending");
endmodule

>>> hw/rtl/ir_distance_median_ema_filter_core.sv
// Two-channel infrared distance filter. Every seventh sample of a channel
// completes its window and yields one result item; other items yield none.
// While a window is being collected an input item is taken every cycle. The
// item that completes a window stalls the input through seven sorting passes
// and the hand-off of the median to a two-entry queue, longer if the queue is
// full. The back stage takes a median, divides serially one quotient bit at a
// time over the 24-bit numerator, adds the offset, clamps, multiplies and sums
// for the average and presents the result until it is accepted, taking no new
// median before that. The queue lets the front collect while the back works.
// Configuration is held in registers written through the cfg channel; the
// user must write them only while no window is in flight, as the block
// itself does not enforce it.
module ir_distance_median_ema_filter_core
    import irdf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    irdf_in_if.sink    in_ch,
    irdf_out_if.source out_ch,
    irdf_cfg_if.sink   cfg_ch
);
    cfg_t                   cfg_reg;
    logic                   fq_valid, fq_ready, qb_valid, qb_ready;
    logic [SAMPLE_BITS:0]   fq_data, qb_data;
    logic                   f_ch;
    logic [SAMPLE_BITS-1:0] f_med;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.numerator_right <= 24'd7574181;
            cfg_reg.offset_right    <= -13'sd26;
            cfg_reg.numerator_front <= 24'd7817807;
            cfg_reg.offset_front    <= 13'd13;
            cfg_reg.min_distance    <= 16'd5120;
            cfg_reg.max_distance    <= 16'd38400;
            cfg_reg.alpha_q16       <= 17'd13107;
            cfg_reg.invalid_limit   <= 12'd1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_NUM_RIGHT:   cfg_reg.numerator_right <= cfg_ch.data;
                REG_OFS_RIGHT:   cfg_reg.offset_right    <= cfg_ch.data[12:0];
                REG_NUM_FRONT:   cfg_reg.numerator_front <= cfg_ch.data;
                REG_OFS_FRONT:   cfg_reg.offset_front    <= cfg_ch.data[12:0];
                REG_MIN_DIST:    cfg_reg.min_distance    <= cfg_ch.data[15:0];
                REG_MAX_DIST:    cfg_reg.max_distance    <= cfg_ch.data[15:0];
                REG_ALPHA:       cfg_reg.alpha_q16       <= cfg_ch.data[16:0];
                REG_INVALID_LIM: cfg_reg.invalid_limit   <= cfg_ch.data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    irdf_front #(.WINDOW_SIZE(WINDOW_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_channel(in_ch.channel), .in_sample(in_ch.sample),
        .med_valid(fq_valid), .med_ready(fq_ready),
        .med_channel(f_ch), .med_value(f_med)
    );

    assign fq_data = {f_ch, f_med};

    irdf_queue #(.WIDTH(SAMPLE_BITS + 1)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    irdf_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .med_valid(qb_valid), .med_ready(qb_ready),
        .med_channel(qb_data[SAMPLE_BITS]), .med_value(qb_data[SAMPLE_BITS-1:0]),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready),
        .res_channel(out_ch.out_channel),
        .res_cal(out_ch.calibrated_distance),
        .res_filt(out_ch.filtered_distance)
    );
endmodule

>>> tb/sv/ir_distance_median_ema_filter_core_tb.sv
module ir_distance_median_ema_filter_core_tb;
    import irdf_pkg::*;

    typedef struct {
        logic        channel;
        logic [11:0] sample;
    } sample_item_t;

    typedef struct {
        logic        channel;
        logic [15:0] cal;
        logic [15:0] filt;
    } distance_t;

    logic clk;
    logic rst_n;

    irdf_in_if #(.SAMPLE_BITS(12)) in_ch ();
    irdf_out_if out_ch ();
    irdf_cfg_if cfg_ch ();

    ir_distance_median_ema_filter_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    logic [23:0] numerator [2];
    logic signed [12:0] offset [2];
    logic [15:0] min_dist;
    logic [15:0] max_dist;
    logic [16:0] alpha;
    logic [11:0] invalid_lim;
    logic [11:0] window [2][7];
    int          fill [2];
    logic [15:0] ema [2];
    logic        seeded [2];

    sample_item_t pending_q[$];
    distance_t    expected_q[$];
    int           mismatches;
    int           results_seen;
    int           items_sent;
    int           idle_cycles;
    logic         steady;
    logic         sender_hold;

    function automatic logic [15:0] clamp_distance(longint d);
        if (d < longint'(min_dist))
            return min_dist;
        if (d > longint'(max_dist))
            return max_dist;
        return d[15:0];
    endfunction

    task automatic predict_distance(input sample_item_t it);
        logic [11:0] s [7];
        logic [11:0] v;
        logic [11:0] med;
        logic [15:0] cal;
        logic [16:0] a;
        longint      acc;
        distance_t   r;
        int          c;
        c = it.channel;
        window[c][fill[c]] = it.sample;
        fill[c]++;
        if (fill[c] < 7)
            return;
        fill[c] = 0;
        s = window[c];
        for (int i = 1; i < 7; i++)
            for (int j = i; j > 0 && s[j-1] > s[j]; j--)
            begin
                v = s[j];
                s[j] = s[j-1];
                s[j-1] = v;
            end
        med = s[3];
        if (med <= invalid_lim)
            cal = clamp_distance(longint'(max_dist));
        else
            cal = clamp_distance(longint'(numerator[c] / med) + longint'(offset[c]));
        if (!seeded[c])
        begin
            ema[c] = cal;
            seeded[c] = 1'b1;
        end
        a = alpha > 17'd65536 ? 17'd65536 : alpha;
        acc = longint'(a) * cal + longint'(65536 - a) * ema[c] + 32768;
        ema[c] = acc[31:16];
        r.channel = it.channel;
        r.cal = cal;
        r.filt = ema[c];
        expected_q.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            items_sent++;
            predict_distance('{in_ch.channel, in_ch.sample});
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.channel <= 1'b0;
            in_ch.sample <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_q.size() > 0 && !sender_hold && (steady || $urandom_range(99) >= 35))
            begin
                in_ch.valid <= 1'b1;
                in_ch.channel <= pending_q[0].channel;
                in_ch.sample <= pending_q[0].sample;
                pending_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= steady || $urandom_range(99) >= 35;
    end

    always @(posedge clk)
    begin
        distance_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ch %0d cal %0d filt %0d", out_ch.out_channel,
                             out_ch.calibrated_distance, out_ch.filtered_distance);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.channel !== out_ch.out_channel || e.cal !== out_ch.calibrated_distance
                    || e.filt !== out_ch.filtered_distance)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ch %0d cal %0d filt %0d, got %0d %0d %0d",
                                 e.channel, e.cal, e.filt, out_ch.out_channel,
                                 out_ch.calibrated_distance, out_ch.filtered_distance);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_NUM_RIGHT:   numerator[0] = value;
            REG_OFS_RIGHT:   offset[0] = value[12:0];
            REG_NUM_FRONT:   numerator[1] = value;
            REG_OFS_FRONT:   offset[1] = value[12:0];
            REG_MIN_DIST:    min_dist = value[15:0];
            REG_MAX_DIST:    max_dist = value[15:0];
            REG_ALPHA:       alpha = value[16:0];
            REG_INVALID_LIM: invalid_lim = value[11:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic add_window(input logic ch, input int kind);
        sample_item_t it;
        for (int i = 0; i < 7; i++)
        begin
            it.channel = ch;
            case (kind)
                0: it.sample = 12'($urandom_range(4095));
                1: it.sample = 12'($urandom_range(3));
                2: it.sample = 12'd4095;
                default: it.sample = 12'($urandom_range(600, 200) + $urandom_range(80));
            endcase
            pending_q.push_back(it);
        end
    endtask

    task automatic add_random(input int n);
        sample_item_t it;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 8)
                add_window(1'($urandom_range(1)), int'($urandom_range(3)));
            else
            begin
                it.channel = 1'($urandom_range(1));
                it.sample = 12'($urandom_range(4095));
                pending_q.push_back(it);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        steady = 1'b0;
        sender_hold = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        numerator[0] = 24'd7574181;
        offset[0] = -13'sd26;
        numerator[1] = 24'd7817807;
        offset[1] = 13'sd13;
        min_dist = 16'd5120;
        max_dist = 16'd38400;
        alpha = 17'd13107;
        invalid_lim = 12'd1;
        for (int c = 0; c < 2; c++)
        begin
            fill[c] = 0;
            ema[c] = '0;
            seeded[c] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero, full scale and an interleaved pair of windows.
        for (int i = 0; i < 7; i++)
            pending_q.push_back('{1'b0, 12'd0});
        for (int i = 0; i < 7; i++)
        begin
            pending_q.push_back('{1'b1, 12'd4095});
            pending_q.push_back('{1'b0, 12'd2 + 12'(i)});
        end
        drain();

        write_register(REG_MIN_DIST, 24'd30000);
        write_register(REG_MAX_DIST, 24'd1000);
        write_register(REG_ALPHA, 24'd65536);
        write_register(REG_INVALID_LIM, 24'd4095);
        add_random(6);
        drain();

        write_register(REG_NUM_RIGHT, 24'hFFFFFF);
        write_register(REG_OFS_RIGHT, 24'hFFF600);
        write_register(REG_NUM_FRONT, 24'd0);
        write_register(REG_OFS_FRONT, 24'd2560);
        write_register(REG_MIN_DIST, 24'd0);
        write_register(REG_MAX_DIST, 24'd65535);
        write_register(REG_ALPHA, 24'h1FFFF);
        write_register(REG_INVALID_LIM, 24'd0);
        add_random(20);
        drain();

        write_register(REG_ALPHA, 24'd0);
        write_register(REG_NUM_FRONT, 24'd7817807);
        write_register(REG_OFS_RIGHT, 24'd4095);
        add_random(30);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_register(REG_NUM_RIGHT, 24'($urandom_range(24'hFFFFFF)));
            write_register(REG_OFS_RIGHT, 24'($urandom_range(5120)) - 24'd2560);
            write_register(REG_NUM_FRONT, 24'($urandom_range(24'hFFFFFF)));
            write_register(REG_OFS_FRONT, 24'($urandom_range(5120)) - 24'd2560);
            write_register(REG_MIN_DIST, 24'($urandom_range(8000)));
            write_register(REG_MAX_DIST, 24'($urandom_range(65535, 20000)));
            write_register(REG_ALPHA, 24'($urandom_range(65536)));
            write_register(REG_INVALID_LIM, 24'($urandom_range(64)));
            steady = (p == 2);
            add_random(50);
            if (p == 1)
            begin
                // Hold the sender mid-stream until every expected result is out.
                repeat (200) @(posedge clk);
                sender_hold = 1'b1;
                while (in_ch.valid || expected_q.size() > 0)
                    @(posedge clk);
                repeat (20) @(posedge clk);
                sender_hold = 1'b0;
            end
            drain();
        end
        steady = 1'b0;

        $display("sent %0d sample items over several register settings, %0d results checked",
                 items_sent, results_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/irdf_pkg.sv
hw/rtl/irdf_if.sv
hw/rtl/irdf_front.sv
hw/rtl/irdf_queue.sv
hw/rtl/irdf_back.sv
hw/rtl/ir_distance_median_ema_filter_core.sv
tb/sv/ir_distance_median_ema_filter_core_tb.sv
